### rtl/btl_pkg.sv
// Shared types and constants for the bakery ticket lock.
package btl_pkg;

    localparam int THREADS_DEF     = 16;
    localparam int TICKET_BITS_DEF = 16;
    localparam int FIELD_TICKET_W  = 16;
    localparam int FIELD_ID_W      = 4;

    localparam logic [1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [FIELD_ID_W-1:0] thread_id;
    } t_req;

    typedef struct packed {
        logic [FIELD_TICKET_W-1:0] ticket_value;
        logic                      may_enter;
        logic [FIELD_ID_W-1:0]     holder_id;
        logic                      holder_valid;
        logic                      overflow;
    } t_rsp;

endpackage

### rtl/btl_ram.sv
// Ticket table memory: one write port, one registered read port.
module btl_ram import btl_pkg::*; #(
    parameter int THREADS     = THREADS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(THREADS)-1:0] i_waddr,
    input  logic [TICKET_BITS-1:0]     i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(THREADS)-1:0] i_raddr,
    output logic [TICKET_BITS-1:0]     o_rdata
);

    logic [TICKET_BITS-1:0] r_mem [THREADS];
    logic [TICKET_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/btl_ctrl.sv
// Request sequencer: clears the table, scans it, updates one ticket, builds the response.
module btl_ctrl import btl_pkg::*; #(
    parameter int THREADS     = THREADS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  t_req                       i_req,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output t_rsp                       o_res,
    output logic                       o_we,
    output logic [$clog2(THREADS)-1:0] o_waddr,
    output logic [TICKET_BITS-1:0]     o_wdata,
    output logic                       o_re,
    output logic [$clog2(THREADS)-1:0] o_raddr,
    input  logic [TICKET_BITS-1:0]     i_rdata
);

    localparam int ID_W = $clog2(THREADS);
    localparam int CW   = ID_W + 1;
    localparam int XW   = ((ID_W > FIELD_ID_W) ? ID_W : FIELD_ID_W) + 1;
    localparam int TVW  = (TICKET_BITS > FIELD_TICKET_W) ? TICKET_BITS : FIELD_TICKET_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [TICKET_BITS-1:0] TOP_TICKET = {TICKET_BITS{1'b1}};

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_rvalid, n_rvalid;
    logic [ID_W-1:0]        r_ridx, n_ridx;
    logic [1:0]             r_kind, n_kind;
    logic [ID_W-1:0]        r_tid, n_tid;
    logic                   r_tid_ok, n_tid_ok;
    logic [TICKET_BITS-1:0] r_max, n_max;
    logic [TICKET_BITS-1:0] r_old, n_old;
    logic [TICKET_BITS-1:0] r_best, n_best;
    logic [ID_W-1:0]        r_best_id, n_best_id;
    logic                   r_best_v, n_best_v;
    t_rsp                   r_res, n_res;

    logic [XW-1:0]          tid_x;
    logic                   ovf;
    logic [TICKET_BITS-1:0] mine;
    logic                   wins;
    logic [ID_W-1:0]        holder;
    logic                   hvalid;
    logic [TVW-1:0]         mine_x;
    logic [XW-1:0]          holder_x;

    assign tid_x    = XW'(i_req.thread_id);
    assign mine_x   = TVW'(mine);
    assign holder_x = XW'(holder);

    always_comb begin
        ovf  = 1'b0;
        mine = '0;
        if (r_tid_ok) begin
            case (r_kind)
                REQ_ACQUIRE: begin
                    ovf  = (r_max == TOP_TICKET);
                    mine = ovf ? r_old : r_max + 1'b1;
                end
                REQ_RELEASE: mine = '0;
                default:     mine = r_old;
            endcase
        end
        wins   = r_tid_ok && (mine != '0) &&
                 (!r_best_v || (mine < r_best) || ((mine == r_best) && (r_tid < r_best_id)));
        holder = wins ? r_tid : r_best_id;
        hvalid = wins || r_best_v;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rvalid  = 1'b0;
        n_ridx    = r_ridx;
        n_kind    = r_kind;
        n_tid     = r_tid;
        n_tid_ok  = r_tid_ok;
        n_max     = r_max;
        n_old     = r_old;
        n_best    = r_best;
        n_best_id = r_best_id;
        n_best_v  = r_best_v;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_cnt[ID_W-1:0];
        o_wdata   = '0;
        o_re      = 1'b0;
        o_raddr   = r_cnt[ID_W-1:0];
        case (r_state)
            S_CLEAR: begin
                o_we  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(THREADS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind    = i_req.req_type;
                    n_tid     = tid_x[ID_W-1:0];
                    n_tid_ok  = tid_x < XW'(THREADS);
                    n_cnt     = '0;
                    n_max     = '0;
                    n_old     = '0;
                    n_best    = '0;
                    n_best_id = '0;
                    n_best_v  = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(THREADS)) begin
                    o_re     = 1'b1;
                    n_rvalid = 1'b1;
                    n_ridx   = r_cnt[ID_W-1:0];
                    n_cnt    = r_cnt + 1'b1;
                end
                if (r_rvalid) begin
                    if (i_rdata > r_max) begin
                        n_max = i_rdata;
                    end
                    if (r_tid_ok && (r_ridx == r_tid)) begin
                        n_old = i_rdata;
                    end else if ((i_rdata != '0) && (!r_best_v || (i_rdata < r_best))) begin
                        n_best    = i_rdata;
                        n_best_id = r_ridx;
                        n_best_v  = 1'b1;
                    end
                    if (r_ridx == ID_W'(THREADS - 1)) begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                o_waddr = r_tid;
                o_wdata = mine;
                o_we    = r_tid_ok && !ovf &&
                          ((r_kind == REQ_ACQUIRE) || (r_kind == REQ_RELEASE));
                n_res.ticket_value = mine_x[FIELD_TICKET_W-1:0];
                n_res.may_enter    = wins;
                n_res.holder_id    = hvalid ? holder_x[FIELD_ID_W-1:0] : '0;
                n_res.holder_valid = hvalid;
                n_res.overflow     = ovf;
                n_state            = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rvalid <= n_rvalid;
        end
        r_ridx    <= n_ridx;
        r_kind    <= n_kind;
        r_tid     <= n_tid;
        r_tid_ok  <= n_tid_ok;
        r_max     <= n_max;
        r_old     <= n_old;
        r_best    <= n_best;
        r_best_id <= n_best_id;
        r_best_v  <= n_best_v;
        r_res     <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

### rtl/bakery_ticket_lock_top.sv
// Bakery ticket lock top level: sequencer, ticket memory and response register.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req) carries a request kind
//   (acquire, release, check; the unused code acts as a check) and a thread id.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp) returns one response
//   per request: the thread's ticket, whether it may enter, the current holder,
//   whether any ticket is held, and an overflow flag for a refused acquire.
//   Each request scans the whole ticket memory through its single read port,
//   one entry per cycle, then an acquire or release that is not refused
//   writes back one entry. One request is worked on at a time: a new request
//   is accepted only after the last one has gone to the response register.
//   After reset the memory is cleared one entry per cycle; o_req_ready stays
//   low until every entry is cleared. The response register holds a finished
//   response while the receiver stalls, and the next request is still
//   accepted and scanned; it waits in the sequencer until that register
//   frees up.
module bakery_ticket_lock_top import btl_pkg::*; #(
    parameter int THREADS     = THREADS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int ID_W = $clog2(THREADS);

    logic                   we;
    logic [ID_W-1:0]        waddr;
    logic [TICKET_BITS-1:0] wdata;
    logic                   re;
    logic [ID_W-1:0]        raddr;
    logic [TICKET_BITS-1:0] rdata;
    logic                   res_valid;
    logic                   res_ready;
    t_rsp                   res;

    logic r_out_valid;
    t_rsp r_out;

    btl_ctrl #(
        .THREADS     (THREADS),
        .TICKET_BITS (TICKET_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    btl_ram #(
        .THREADS     (THREADS),
        .TICKET_BITS (TICKET_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign res_ready = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
